// File: rtl/cbf_pkg.sv
package cbf_pkg;

   localparam logic [7:0] SOH_BYTE   = 8'h01;
   localparam logic [7:0] STX_BYTE   = 8'h02;
   localparam logic [7:0] ETX_BYTE   = 8'h03;
   localparam logic [7:0] ESC_BYTE   = 8'h1B;
   localparam logic [7:0] CRC_POLY   = 8'h85;
   localparam logic [7:0] ADDR_RESET = 8'h41;

   localparam int MAX_BYTES = 5;
   localparam int IDX_W     = 3;

   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [IDX_W-1:0]          count;
      logic                      frame_end;
   } job_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         if (c[7] ^ data[i]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic needs_escape(input logic [7:0] b);
      return (b == SOH_BYTE) || (b == STX_BYTE) || (b == ETX_BYTE) || (b == ESC_BYTE);
   endfunction

endpackage

// File: rtl/cbf_queue.sv
module cbf_queue
   import cbf_pkg::*;
#(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output job_type head_job
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count out of range");

endmodule

// File: rtl/cbf_front.sv
module cbf_front
   import cbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   input  logic [7:0] address_byte,
   input  logic       queue_full,
   output logic       push,
   output job_type    push_job
);

   logic [7:0] crc_ff, crc_in;
   logic       inside_ff, inside_in;
   logic [7:0] crc_next;
   logic       esc_data;
   logic       esc_crc;
   logic       closing;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign crc_next  = crc8_update(crc_ff, req_data_byte);
   assign esc_data  = needs_escape(req_data_byte);
   assign esc_crc   = needs_escape(crc_next);
   assign closing   = inside_ff && req_last_byte;

   always_comb begin
      logic [IDX_W-1:0] p;
      push_job = '0;
      p        = '0;
      if (!inside_ff) begin
         push_job.bytes[0] = SOH_BYTE;
         push_job.bytes[1] = address_byte;
         push_job.bytes[2] = STX_BYTE;
         p = IDX_W'(3);
      end
      if (esc_data) begin
         push_job.bytes[p] = ESC_BYTE;
         p = p + IDX_W'(1);
      end
      push_job.bytes[p] = req_data_byte;
      p = p + IDX_W'(1);
      if (closing) begin
         if (esc_crc) begin
            push_job.bytes[p] = ESC_BYTE;
            p = p + IDX_W'(1);
         end
         push_job.bytes[p] = crc_next;
         p = p + IDX_W'(1);
         push_job.bytes[p] = ETX_BYTE;
         p = p + IDX_W'(1);
         push_job.frame_end = 1'b1;
      end
      push_job.count = p;
   end

   always_comb begin
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (push) begin
         if (!inside_ff) begin
            crc_in    = '0;
            inside_in = 1'b1;
         end else if (req_last_byte) begin
            crc_in    = '0;
            inside_in = 1'b0;
         end else begin
            crc_in = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= '0;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         inside_ff <= inside_in;
      end
   end

   a_crc_zero_outside: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> crc_ff == '0)
      else $error("crc not cleared between frames");

   a_open_after_length: assert property (@(posedge clock) disable iff (reset)
      push && !inside_ff |=> inside_ff)
      else $error("length byte did not open frame");

   a_close_on_last: assert property (@(posedge clock) disable iff (reset)
      push && closing |=> !inside_ff && crc_ff == '0)
      else $error("last byte did not close frame");

endmodule

// File: rtl/cbf_back.sv
module cbf_back
   import cbf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       queue_empty,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             run_last_ff, run_last_in;
   logic             frame_end_ff, frame_end_in;
   logic             load;
   logic             at_end;

   assign load   = !valid_ff || !rsp_stall;
   assign at_end = (idx_ff == head_job.count - IDX_W'(1));
   assign pop    = load && !queue_empty && at_end;

   always_comb begin
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      byte_in      = byte_ff;
      run_last_in  = run_last_ff;
      frame_end_in = frame_end_ff;
      if (load) begin
         valid_in = !queue_empty;
         if (!queue_empty) begin
            byte_in      = head_job.bytes[idx_ff];
            run_last_in  = at_end;
            frame_end_in = at_end && head_job.frame_end;
            idx_in       = at_end ? '0 : idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      run_last_ff  <= run_last_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_line_byte = byte_ff;
   assign rsp_run_last  = run_last_ff;
   assign rsp_frame_end = frame_end_ff;

   a_end_is_run_last: assert property (@(posedge clock) disable iff (reset)
      valid_ff && frame_end_ff |-> run_last_ff && byte_ff == ETX_BYTE)
      else $error("frame end not on closing ETX");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !queue_empty |-> idx_ff < head_job.count)
      else $error("byte index beyond job");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      queue_empty |-> idx_ff == '0)
      else $error("byte index left mid job");

endmodule

// File: rtl/crc8_byte_stuffed_packet_framer_top.sv
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  req_data_byte[7:0], req_last_byte
// rsp      out  rsp_valid/rsp_stall  rsp_line_byte[7:0], rsp_run_last, rsp_frame_end
// csr      in   csr_valid/csr_ready  csr_data[7:0] (address byte)
//
// One line byte leaves per cycle while rsp_stall is low and a job waits; an input
// yields 1 to 5 bytes, sent from the single output register of the byte sequencer.
// Input is taken every cycle while the job queue has room (QUEUE_DEPTH entries).
// Reset is synchronous: empties the queue, clears the CRC, address back to 0x41.
// rsp_stall holds the output register; req_stall rises only when the queue is full.
module crc8_byte_stuffed_packet_framer_top
   import cbf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_run_last,
   output logic       rsp_frame_end,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] addr_ff, addr_in;
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       queue_empty;
   job_type    push_job;
   job_type    head_job;

   assign csr_ready = 1'b1;
   assign addr_in   = (csr_valid && csr_ready) ? csr_data : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET;
      end else begin
         addr_ff <= addr_in;
      end
   end

   cbf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .address_byte  (addr_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   cbf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (queue_full),
      .empty    (queue_empty),
      .head_job (head_job)
   );

   cbf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_line_byte (rsp_line_byte),
      .rsp_run_last  (rsp_run_last),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
